@@ src/blr_pkg.sv @@
// Shared types and constants for the Bresenham line rasterizer.
// No dependencies; compile first.
`default_nettype none

package blr_pkg;

  localparam int ADDR_W    = 32;
  localparam int COLOR_W   = 16;
  localparam int ROW_SHIFT = 10;

  localparam logic [ADDR_W-1:0] FRAME_BASE_RESET = 32'hC800_0000;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

endpackage

`default_nettype wire

@@ src/blr_in_if.sv @@
// Command channel of the line rasterizer: start / step words with endpoints.
// Depends on blr_pkg.
`default_nettype none

interface blr_in_if import blr_pkg::*; #(
  parameter int X_BITS = 9,
  parameter int Y_BITS = 8
);
  logic               valid;
  logic               ready;
  op_t                op;
  logic [X_BITS-1:0]  x_from;
  logic [Y_BITS-1:0]  y_from;
  logic [X_BITS-1:0]  x_to;
  logic [Y_BITS-1:0]  y_to;
  logic [COLOR_W-1:0] color_in;

  modport source (
    output valid, op, x_from, y_from, x_to, y_to, color_in,
    input  ready
  );

  modport sink (
    input  valid, op, x_from, y_from, x_to, y_to, color_in,
    output ready
  );
endinterface

`default_nettype wire

@@ src/blr_out_if.sv @@
// Pixel channel of the line rasterizer: one word per plotted pixel.
// Depends on blr_pkg.
`default_nettype none

interface blr_out_if import blr_pkg::*; #(
  parameter int X_BITS = 9,
  parameter int Y_BITS = 8
);
  logic               valid;
  logic               ready;
  logic [X_BITS-1:0]  pixel_x;
  logic [Y_BITS-1:0]  pixel_y;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;
  logic               last_pixel;

  modport source (
    output valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, pixel_y, pixel_address, pixel_color, last_pixel,
    output ready
  );
endinterface

`default_nettype wire

@@ src/bresenham_line_raster.sv @@
// Bresenham line rasterizer top level: line state, step update, pixel register.
// Depends on blr_pkg, blr_in_if and blr_out_if.
//
//   channel   dir  handshake        word
//   in_chan   in   valid/ready      op, x_from, y_from, x_to, y_to, color_in
//   out_chan  out  valid/ready      pixel_x, pixel_y, pixel_address, pixel_color,
//                                   last_pixel
//   cfg_*     in   cfg_wr_en        cfg_wr_data -> frame_base
//
// One word per cycle unless out_chan stalls: a step word updates the line state
// in the cycle it is taken; its pixel is in the output register the next cycle.
// The cycle is set by the error add, compare and subtract plus the address add.
// A new word is taken whenever the output register is empty or being drained.
// Reset (synchronous, rst_n low) leaves the rasterizer idle, frame base at its
// default; step words while idle are consumed with no pixel.
`default_nettype none

module bresenham_line_raster import blr_pkg::*; #(
  parameter int X_BITS = 9,
  parameter int Y_BITS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wr_en,
  input  wire logic [ADDR_W-1:0] cfg_wr_data,
  blr_in_if.sink                 in_chan,
  blr_out_if.source              out_chan
);

  localparam int M_BITS = (X_BITS > Y_BITS) ? X_BITS : Y_BITS;
  localparam int E_BITS = M_BITS + 2;

  // line state
  logic [ADDR_W-1:0]        frame_base_r;
  logic                     active_r;
  logic                     steep_r;
  logic                     minor_dec_r;
  logic [M_BITS-1:0]        major_pos_r, major_pos_nxt;
  logic [M_BITS-1:0]        major_end_r, major_end_nxt;
  logic [M_BITS-1:0]        minor_pos_r, minor_pos_nxt;
  logic [M_BITS-1:0]        major_dlt_r, major_dlt_nxt;
  logic [M_BITS-1:0]        minor_dlt_r, minor_dlt_nxt;
  logic signed [E_BITS-1:0] err_r, err_nxt;
  logic [COLOR_W-1:0]       color_r;
  logic                     active_nxt, steep_nxt, minor_dec_nxt;

  // output register
  logic                     out_valid_r, out_valid_nxt;
  logic [X_BITS-1:0]        px_r;
  logic [Y_BITS-1:0]        py_r;
  logic [ADDR_W-1:0]        addr_r;
  logic [COLOR_W-1:0]       pcolor_r;
  logic                     last_r;

  logic in_acc;
  logic do_start;
  logic do_step;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;
  assign do_start      = in_acc && (in_chan.op == OP_START);
  assign do_step       = in_acc && (in_chan.op == OP_STEP) && active_r;

  // ---------------- start: set up the octant ----------------
  logic [M_BITS-1:0] xa, xb, ya, yb, dx, dy;
  logic [M_BITS-1:0] ma, mb, na, nb, m_lo, m_hi, n_lo, n_hi;
  logic              steep_s;

  always_comb begin
    xa = M_BITS'(in_chan.x_from);
    xb = M_BITS'(in_chan.x_to);
    ya = M_BITS'(in_chan.y_from);
    yb = M_BITS'(in_chan.y_to);
    dx = (xa > xb) ? (xa - xb) : (xb - xa);
    dy = (ya > yb) ? (ya - yb) : (yb - ya);
    steep_s = dy > dx;
    ma = steep_s ? ya : xa;
    na = steep_s ? xa : ya;
    mb = steep_s ? yb : xb;
    nb = steep_s ? xb : yb;
    // order so the major axis runs upward
    if (ma > mb) begin
      m_lo = mb; m_hi = ma; n_lo = nb; n_hi = na;
    end else begin
      m_lo = ma; m_hi = mb; n_lo = na; n_hi = nb;
    end
  end

  // ---------------- step: emit pixel, advance ----------------
  logic                     last_s;
  logic [X_BITS-1:0]        px_s;
  logic [Y_BITS-1:0]        py_s;
  logic [ADDR_W-1:0]        addr_s;
  logic signed [E_BITS-1:0] err_sum;
  logic                     bend;

  always_comb begin
    last_s  = major_pos_r == major_end_r;
    px_s    = steep_r ? X_BITS'(minor_pos_r) : X_BITS'(major_pos_r);
    py_s    = steep_r ? Y_BITS'(major_pos_r) : Y_BITS'(minor_pos_r);
    addr_s  = frame_base_r + (ADDR_W'(py_s) << ROW_SHIFT) + (ADDR_W'(px_s) << 1);
    err_sum = err_r + $signed({2'b00, minor_dlt_r});
    bend    = !err_sum[E_BITS-1] && (err_sum != '0);
  end

  always_comb begin
    active_nxt    = active_r;
    steep_nxt     = steep_r;
    minor_dec_nxt = minor_dec_r;
    major_pos_nxt = major_pos_r;
    major_end_nxt = major_end_r;
    minor_pos_nxt = minor_pos_r;
    major_dlt_nxt = major_dlt_r;
    minor_dlt_nxt = minor_dlt_r;
    err_nxt       = err_r;
    if (do_start) begin
      active_nxt    = 1'b1;
      steep_nxt     = steep_s;
      minor_dec_nxt = !(n_lo < n_hi);
      major_pos_nxt = m_lo;
      major_end_nxt = m_hi;
      minor_pos_nxt = n_lo;
      major_dlt_nxt = m_hi - m_lo;
      minor_dlt_nxt = (n_lo > n_hi) ? (n_lo - n_hi) : (n_hi - n_lo);
      err_nxt       = -$signed({2'b00, (m_hi - m_lo) >> 1});
    end else if (do_step) begin
      if (last_s) begin
        active_nxt = 1'b0;
      end else begin
        major_pos_nxt = major_pos_r + 1'b1;
        if (bend) begin
          minor_pos_nxt = minor_dec_r ? (minor_pos_r - 1'b1) : (minor_pos_r + 1'b1);
          err_nxt       = err_sum - $signed({2'b00, major_dlt_r});
        end else begin
          err_nxt = err_sum;
        end
      end
    end
  end

  always_comb begin
    if (in_acc) begin
      out_valid_nxt = do_step;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_base_r <= FRAME_BASE_RESET;
      active_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        frame_base_r <= cfg_wr_data;
      end
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    steep_r     <= steep_nxt;
    minor_dec_r <= minor_dec_nxt;
    major_pos_r <= major_pos_nxt;
    major_end_r <= major_end_nxt;
    minor_pos_r <= minor_pos_nxt;
    major_dlt_r <= major_dlt_nxt;
    minor_dlt_r <= minor_dlt_nxt;
    err_r       <= err_nxt;
    if (do_start) begin
      color_r <= in_chan.color_in;
    end
    if (do_step) begin
      px_r     <= px_s;
      py_r     <= py_s;
      addr_r   <= addr_s;
      pcolor_r <= color_r;
      last_r   <= last_s;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.pixel_x       = px_r;
  assign out_chan.pixel_y       = py_r;
  assign out_chan.pixel_address = addr_r;
  assign out_chan.pixel_color   = pcolor_r;
  assign out_chan.last_pixel    = last_r;

  // ---------------- checks ----------------
  a_step_gives_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    do_step |=> out_chan.valid)
    else $error("step on an active line gave no pixel");

  a_start_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
    do_start |=> (!out_chan.valid && active_r))
    else $error("start word left a pixel pending or the line idle");

  a_last_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.last_pixel) |-> !active_r)
    else $error("line still active while its last pixel is shown");

  a_err_nonpositive: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (err_r[E_BITS-1] || (err_r == '0)))
    else $error("error term positive between steps");

endmodule

`default_nettype wire
